@@ rtl/prqs_pkg.sv @@
// prqs_pkg: shared types and constants of the ready-queue scheduler
// depends on nothing
`default_nettype none
package prqs_pkg;
	localparam logic [2:0] CMD_READY   = 3'd0;
	localparam logic [2:0] CMD_UNREADY = 3'd1;
	localparam logic [2:0] CMD_REPRIO  = 3'd2;
	localparam logic [2:0] CMD_RESCHED = 3'd3;
	localparam logic [2:0] CMD_YIELD   = 3'd4;
	localparam logic [2:0] CMD_LOCK    = 3'd5;
	localparam logic [2:0] CMD_UNLOCK  = 3'd6;

	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	localparam int DEFAULT_PRIORITY = 16;

	// datapath operations issued by the controller
	localparam logic [2:0] OP_NOP     = 3'd0;
	localparam logic [2:0] OP_EXEC    = 3'd1; // ready/unready/reprio/lock/unlock
	localparam logic [2:0] OP_SEL_CHK = 3'd2; // decide keep or requeue running slot
	localparam logic [2:0] OP_SEL_PUT = 3'd3; // requeue running slot
	localparam logic [2:0] OP_SEL_GET = 3'd4; // dispatch best head or report idle

	typedef struct packed {
		logic [2:0] op;
		logic       yield_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic hint;
		logic locked;
		logic keep;
	} dp_status_t;
endpackage
`default_nettype wire

@@ rtl/prqs_ctrl.sv @@
// prqs_ctrl: sequencer of one command through the datapath
// depends on prqs_pkg
`default_nettype none
module prqs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        command,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire prqs_pkg::dp_status_t stat,
	output prqs_pkg::ctl_cmd_t     ctl,
	output logic                   load_out
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_GET  = 3'd3;

	logic [2:0] state_q;
	logic       yield_q;
	logic       slot_free;

	// output register free or being drained this cycle
	assign slot_free = !out_valid || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;

	always_comb begin
		ctl.op        = prqs_pkg::OP_NOP;
		ctl.yield_sel = yield_q;
		load_out      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					ctl.op = prqs_pkg::OP_EXEC;
					if (command == prqs_pkg::CMD_YIELD ||
						(command == prqs_pkg::CMD_RESCHED && stat.hint)) begin
						if (stat.locked)
							load_out = 1'b1;
					end else
						load_out = 1'b1;
				end
			end
			S_CHK: begin
				ctl.op   = prqs_pkg::OP_SEL_CHK;
				// a kept running slot ends the selection with an empty result
				load_out = stat.keep;
			end
			S_PUT: ctl.op = prqs_pkg::OP_SEL_PUT;
			S_GET: begin
				ctl.op   = prqs_pkg::OP_SEL_GET;
				load_out = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			yield_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready && !stat.locked &&
						(command == prqs_pkg::CMD_YIELD ||
						(command == prqs_pkg::CMD_RESCHED && stat.hint))) begin
						yield_q <= (command == prqs_pkg::CMD_YIELD);
						state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= stat.keep ? S_IDLE : S_PUT;
				S_PUT: state_q <= S_GET;
				S_GET: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/prqs_dpath.sv @@
// prqs_dpath: slot tables, level lists, occupancy bitmap and lock counter
// depends on prqs_pkg
`default_nettype none
module prqs_dpath #(
	parameter int NUM_SLOTS  = 32,
	parameter int NUM_LEVELS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prqs_pkg::ctl_cmd_t ctl,
	input  wire logic [2:0]        command,
	input  wire logic [4:0]        thread_id,
	input  wire logic [4:0]        new_priority,
	output prqs_pkg::dp_status_t   stat,
	output logic [4:0]             sel_thread,
	output logic                   sel_switched,
	output logic                   sel_idle,
	output logic signed [7:0]      lock_prior
);
	localparam int SW = (NUM_SLOTS > 32) ? 6 : 5;   // slot index width
	localparam int PW = 6;                          // pointer width, top bit is none
	localparam int DEF_PRI = (prqs_pkg::DEFAULT_PRIORITY < NUM_LEVELS) ?
		prqs_pkg::DEFAULT_PRIORITY : NUM_LEVELS - 1;

	logic [PW-1:0] head_q [NUM_LEVELS];
	logic [PW-1:0] tail_q [NUM_LEVELS];
	logic [PW-1:0] next_q [NUM_SLOTS];
	logic [PW-1:0] prev_q [NUM_SLOTS];
	logic [4:0]    prio_q [NUM_SLOTS];
	logic [1:0]    stat_q [NUM_SLOTS];
	logic [NUM_LEVELS-1:0] occ_q;   // bit p = level p non-empty
	logic [PW-1:0] run_q;
	logic          hint_q;
	logic signed [7:0] lock_q;

	function automatic logic ptr_ok(input logic [PW-1:0] v);
		return (32'(v) < NUM_SLOTS) && !v[PW-1];
	endfunction

	// best level: lowest set bit
	logic [4:0] best;
	logic       any_occ;
	always_comb begin
		best = 5'd31;
		for (int i = NUM_LEVELS - 1; i >= 0; i--)
			if (occ_q[i]) best = 5'(i);
		any_occ = |occ_q;
	end

	logic [SW-1:0] t;
	logic t_ok, p_ok;
	assign t    = SW'(thread_id);
	assign t_ok = (32'(thread_id) < NUM_SLOTS);
	assign p_ok = (32'(new_priority) < NUM_LEVELS);

	logic [SW-1:0] cur;
	logic cur_ok;
	assign cur    = run_q[SW-1:0];
	assign cur_ok = ptr_ok(run_q);

	always_comb begin
		stat.hint   = hint_q;
		stat.locked = (lock_q > 8'sd0);
		stat.keep   = 1'b1;
		if (cur_ok && stat_q[cur] == prqs_pkg::ST_RUNNING)
			stat.keep = !ctl.yield_sel && (!any_occ || prio_q[cur] <= best);
		else
			stat.keep = 1'b0;
	end

	// in the selection, enqueue (put) and unlink (get) are separate operations; in
	// reprioritize, unlink of a slot, then enqueue of the same slot is chained in
	// the same cycle through local copies
	logic [PW-1:0] h_n [NUM_LEVELS];
	logic [PW-1:0] tl_n [NUM_LEVELS];
	logic [PW-1:0] nx_n [NUM_SLOTS];
	logic [PW-1:0] pv_n [NUM_SLOTS];
	logic [4:0]    pr_n [NUM_SLOTS];
	logic [1:0]    st_n [NUM_SLOTS];
	logic [NUM_LEVELS-1:0] occ_n;
	logic [PW-1:0] run_n;
	logic          hint_n;
	logic signed [7:0] lock_n;
	logic [4:0] o_thr;
	logic o_sw, o_idle;
	logic signed [7:0] o_lock;

	logic [SW-1:0] ul_s, eq_s;
	logic          do_ul, do_eq;
	logic [4:0]    ul_p, eq_p;
	logic [PW-1:0] ul_nx, ul_pv, eq_pv, ul_hd;

	always_comb begin
		h_n = head_q; tl_n = tail_q; nx_n = next_q; pv_n = prev_q;
		pr_n = prio_q; st_n = stat_q; occ_n = occ_q; run_n = run_q;
		hint_n = hint_q; lock_n = lock_q;
		o_thr = 5'd0; o_sw = 1'b0; o_idle = 1'b0; o_lock = 8'sd0;
		do_ul = 1'b0; do_eq = 1'b0; ul_s = t; eq_s = t;
		ul_p = 5'd0; eq_p = 5'd0; ul_nx = '0; ul_pv = '0; eq_pv = '0; ul_hd = '0;
		case (ctl.op)
			prqs_pkg::OP_EXEC: begin
				case (command)
					prqs_pkg::CMD_READY:
						if (t_ok && p_ok && stat_q[t] == prqs_pkg::ST_NONE) begin
							pr_n[t] = new_priority;
							st_n[t] = prqs_pkg::ST_READY;
							do_eq = 1'b1; eq_p = new_priority;
						end
					prqs_pkg::CMD_UNREADY:
						if (t_ok && stat_q[t] == prqs_pkg::ST_READY) begin
							do_ul = 1'b1; ul_p = prio_q[t];
							st_n[t] = prqs_pkg::ST_NONE;
						end else if (t_ok && stat_q[t] == prqs_pkg::ST_RUNNING) begin
							st_n[t] = prqs_pkg::ST_NONE;
							hint_n = 1'b1;
						end
					prqs_pkg::CMD_REPRIO:
						if (t_ok && p_ok && prio_q[t] != new_priority) begin
							if (stat_q[t] == prqs_pkg::ST_READY) begin
								do_ul = 1'b1; ul_p = prio_q[t];
								do_eq = 1'b1; eq_p = new_priority;
								pr_n[t] = new_priority;
							end else if (stat_q[t] == prqs_pkg::ST_RUNNING) begin
								pr_n[t] = new_priority;
								hint_n = 1'b1;
							end
						end
					prqs_pkg::CMD_LOCK: begin
						o_lock = lock_q;
						if (lock_q != 8'sh7f) lock_n = lock_q + 8'sd1;
					end
					prqs_pkg::CMD_UNLOCK: begin
						o_lock = lock_q;
						if (lock_q != 8'sh80) lock_n = lock_q - 8'sd1;
					end
					default: ;
				endcase
			end
			prqs_pkg::OP_SEL_PUT: begin
				// only a slot that is still running goes back to its level
				if (cur_ok && stat_q[cur] == prqs_pkg::ST_RUNNING) begin
					st_n[cur] = prqs_pkg::ST_READY;
					eq_s = cur; do_eq = 1'b1; eq_p = prio_q[cur];
				end
			end
			prqs_pkg::OP_SEL_GET: begin
				hint_n = 1'b0;
				if (!any_occ) begin
					run_n = PW'(32);
					o_idle = 1'b1;
				end else if (ptr_ok(head_q[best])) begin
					ul_s = head_q[best][SW-1:0]; do_ul = 1'b1; ul_p = best;
					st_n[ul_s] = prqs_pkg::ST_RUNNING;
					run_n = PW'(ul_s);
					o_thr = 5'(ul_s); o_sw = 1'b1;
				end
			end
			default: ;
		endcase
		if (do_ul) begin
			ul_nx = next_q[ul_s]; ul_pv = prev_q[ul_s];
			if (ptr_ok(ul_nx)) pv_n[ul_nx[SW-1:0]] = ul_pv;
			else tl_n[ul_p] = ul_pv;
			if (ptr_ok(ul_pv)) nx_n[ul_pv[SW-1:0]] = ul_nx;
			else h_n[ul_p] = ul_nx;
			ul_hd = h_n[ul_p];
			if (!ptr_ok(ul_hd)) occ_n[ul_p] = 1'b0;
		end
		if (do_eq) begin
			eq_pv = tl_n[eq_p];
			if (ptr_ok(eq_pv)) nx_n[eq_pv[SW-1:0]] = PW'(eq_s);
			else h_n[eq_p] = PW'(eq_s);
			pv_n[eq_s] = eq_pv;
			nx_n[eq_s] = PW'(32);
			tl_n[eq_p] = PW'(eq_s);
			occ_n[eq_p] = 1'b1;
			hint_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= PW'(32);
				tail_q[i] <= PW'(32);
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				stat_q[i] <= prqs_pkg::ST_NONE;
				prio_q[i] <= 5'd0;
			end
			stat_q[0] <= prqs_pkg::ST_RUNNING;
			prio_q[0] <= 5'(DEF_PRI);
			occ_q  <= '0;
			run_q  <= '0;
			hint_q <= 1'b0;
			lock_q <= 8'sd0;
		end else begin
			head_q <= h_n; tail_q <= tl_n; prio_q <= pr_n; stat_q <= st_n;
			occ_q <= occ_n; run_q <= run_n; hint_q <= hint_n; lock_q <= lock_n;
		end
	end

	// links have undefined reset
	always_ff @(posedge clk) begin
		next_q <= nx_n;
		prev_q <= pv_n;
	end

	assign sel_thread   = o_thr;
	assign sel_switched = o_sw;
	assign sel_idle     = o_idle;
	assign lock_prior   = o_lock;
endmodule
`default_nettype wire

@@ rtl/priority_ready_queue_scheduler.sv @@
// priority_ready_queue_scheduler: top level of the ready-queue scheduler
// depends on prqs_pkg, prqs_ctrl, prqs_dpath
//
// channel  | handshake          | fields
// in       | in_valid/in_ready  | command, thread_id, new_priority
// out      | out_valid/out_ready| selected_thread, switched, idle, prior_lock_count
//
// one beat in gives one beat out. most commands are done in the idle state; a
// reschedule with the hint set or a yield, while unlocked, walks the selection
// sequencer: check, then back to idle when the running slot is kept, or put
// and get when it is requeued and a head dispatched. a result waiting in the
// output register holds in_ready low unless it drains in the same cycle. arst_n
// clears level lists, slot status, bitmap, hint and lock; slot 0 starts running.
`default_nettype none
module priority_ready_queue_scheduler #(
	parameter int NUM_SLOTS  = 32,
	parameter int NUM_LEVELS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        command,
	input  wire logic [4:0]        thread_id,
	input  wire logic [4:0]        new_priority,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [4:0]             selected_thread,
	output logic                   switched,
	output logic                   idle,
	output logic signed [7:0]      prior_lock_count
);
	prqs_pkg::ctl_cmd_t   ctl;
	prqs_pkg::dp_status_t stat;
	logic load_out;
	logic [4:0] r_thr;
	logic r_sw, r_idle;
	logic signed [7:0] r_lock;

	prqs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .ctl(ctl), .load_out(load_out)
	);

	prqs_dpath #(.NUM_SLOTS(NUM_SLOTS), .NUM_LEVELS(NUM_LEVELS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .command(command),
		.thread_id(thread_id), .new_priority(new_priority), .stat(stat),
		.sel_thread(r_thr), .sel_switched(r_sw), .sel_idle(r_idle),
		.lock_prior(r_lock)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load_out)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			selected_thread  <= r_thr;
			switched         <= r_sw;
			idle             <= r_idle;
			prior_lock_count <= r_lock;
		end
	end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for priority_ready_queue_scheduler
// holds its own scheduler predictor in a scoreboard class; depends on prqs_pkg and the rtl
`default_nettype none
module tb;
	localparam logic [5:0] NO_SLOT = 6'h20;
	localparam logic [2:0] CMD_UNKNOWN = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	// one result beat
	typedef struct packed {
		logic [4:0]        sel;
		logic              sw;
		logic              idl;
		logic signed [7:0] plc;
	} sched_res_t;

	// predictor of the scheduler plus the queue of results still owed
	class sched_scoreboard;
		logic [5:0] head[32], tail[32], nxt[32], prv[32];
		logic [4:0] prio[32];
		logic [1:0] stat[32];
		logic [31:0] occ;
		logic [5:0] run;
		bit hint;
		int lock_cnt;
		int errors;
		sched_res_t res;
		sched_res_t owed[$];

		function void clear();
			for (int i = 0; i < 32; i++) begin
				head[i] = NO_SLOT;
				tail[i] = NO_SLOT;
				nxt[i] = '0;
				prv[i] = '0;
				prio[i] = '0;
				stat[i] = prqs_pkg::ST_NONE;
			end
			prio[0] = 5'(prqs_pkg::DEFAULT_PRIORITY);
			stat[0] = prqs_pkg::ST_RUNNING;
			occ = '0;
			run = '0;
			hint = 0;
			lock_cnt = 0;
			errors = 0;
		endfunction

		// leading-zero encode; 32 means no level occupied
		function int best();
			for (int n = 0; n < 32; n++)
				if (occ[31-n])
					return n;
			return 32;
		endfunction

		function void put_tail(logic [4:0] t);
			logic [4:0] p;
			logic [5:0] pv;
			p = prio[t];
			pv = tail[p];
			if (!pv[5])
				nxt[pv[4:0]] = {1'b0, t};
			else
				head[p] = {1'b0, t};
			prv[t] = pv;
			nxt[t] = NO_SLOT;
			tail[p] = {1'b0, t};
			occ[31-p] = 1'b1;
			hint = 1;
		endfunction

		function void unlink(logic [4:0] t);
			logic [4:0] p;
			logic [5:0] nx, pv;
			p = prio[t];
			nx = nxt[t];
			pv = prv[t];
			if (!nx[5])
				prv[nx[4:0]] = pv;
			else
				tail[p] = pv;
			if (!pv[5])
				nxt[pv[4:0]] = nx;
			else
				head[p] = nx;
			if (head[p][5])
				occ[31-p] = 1'b0;
		endfunction

		function void pick(bit yld);
			logic [5:0] cur, nx;
			int p;
			cur = run;
			if (lock_cnt > 0)
				return;
			if (!cur[5] && stat[cur[4:0]] == prqs_pkg::ST_RUNNING) begin
				if (!yld && int'(prio[cur[4:0]]) <= best())
					return;
				stat[cur[4:0]] = prqs_pkg::ST_READY;
				put_tail(cur[4:0]);
			end
			hint = 0;
			if (occ == '0) begin
				run = NO_SLOT;
				res.idl = 1;
				return;
			end
			p = best();
			nx = head[p];
			unlink(nx[4:0]);
			stat[nx[4:0]] = prqs_pkg::ST_RUNNING;
			run = nx;
			res.sel = nx[4:0];
			res.sw = 1;
		endfunction

		// an accepted command beat: advance the predictor and owe one result
		function void note_command(logic [2:0] c, logic [4:0] t, logic [4:0] np);
			res = '0;
			case (c)
				prqs_pkg::CMD_READY: if (stat[t] == prqs_pkg::ST_NONE) begin
					prio[t] = np;
					stat[t] = prqs_pkg::ST_READY;
					put_tail(t);
				end
				prqs_pkg::CMD_UNREADY: if (stat[t] == prqs_pkg::ST_READY) begin
					unlink(t);
					stat[t] = prqs_pkg::ST_NONE;
				end else if (stat[t] == prqs_pkg::ST_RUNNING) begin
					stat[t] = prqs_pkg::ST_NONE;
					hint = 1;
				end
				prqs_pkg::CMD_REPRIO: if (prio[t] != np) begin
					if (stat[t] == prqs_pkg::ST_READY) begin
						unlink(t);
						prio[t] = np;
						put_tail(t);
					end else if (stat[t] == prqs_pkg::ST_RUNNING) begin
						prio[t] = np;
						hint = 1;
					end
				end
				prqs_pkg::CMD_RESCHED: if (hint)
					pick(0);
				prqs_pkg::CMD_YIELD: pick(1);
				prqs_pkg::CMD_LOCK: begin
					res.plc = lock_cnt[7:0];
					if (lock_cnt < 127)
						lock_cnt++;
				end
				prqs_pkg::CMD_UNLOCK: begin
					res.plc = lock_cnt[7:0];
					if (lock_cnt > -128)
						lock_cnt--;
				end
				default: ;
			endcase
			owed.push_back(res);
		endfunction

		function void check_result(sched_res_t got);
			sched_res_t want;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.sel !== want.sel) begin
				$display("%0t: selected_thread expected %0d actual %0d", $time, want.sel, got.sel);
				errors++;
			end
			if (got.sw !== want.sw) begin
				$display("%0t: switched expected %0d actual %0d", $time, want.sw, got.sw);
				errors++;
			end
			if (got.idl !== want.idl) begin
				$display("%0t: idle expected %0d actual %0d", $time, want.idl, got.idl);
				errors++;
			end
			if (got.plc !== want.plc) begin
				$display("%0t: prior_lock_count expected %0d actual %0d", $time,
					want.plc, got.plc);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] command = '0;
	logic [4:0] thread_id = '0;
	logic [4:0] new_priority = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [4:0] selected_thread;
	logic switched;
	logic idle;
	logic signed [7:0] prior_lock_count;

	sched_scoreboard sb;
	int send_gap_pct = 0;   // chance of an idle cycle before each command beat
	int stall_pct = 0;      // chance the receiver stalls in a cycle
	bit hold_req = 0;       // asks the receiver for one long hold-off
	int hold_left = 0;
	int quiet_cycles = 0;

	priority_ready_queue_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.thread_id(thread_id),
		.new_priority(new_priority),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.selected_thread(selected_thread),
		.switched(switched),
		.idle(idle),
		.prior_lock_count(prior_lock_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result side: check accepted beats, then choose ready for the next edge
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result({selected_thread, switched, idle, prior_lock_count});
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles where neither channel moves a beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// one command beat, with an optional random gap in front of it
	task automatic send_beat(logic [2:0] c, logic [4:0] t, logic [4:0] np);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		thread_id <= t;
		new_priority <= np;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_command(c, t, np);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	// mostly scheduler traffic on a few crowded levels; lock kept near zero
	task automatic send_random(int n);
		int r;
		logic [2:0] c;
		logic [4:0] np;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 30)
				c = prqs_pkg::CMD_READY;
			else if (r < 44)
				c = prqs_pkg::CMD_UNREADY;
			else if (r < 58)
				c = prqs_pkg::CMD_REPRIO;
			else if (r < 78)
				c = prqs_pkg::CMD_RESCHED;
			else if (r < 90)
				c = prqs_pkg::CMD_YIELD;
			else if (r < 99)
				c = (sb.lock_cnt > 0 || (sb.lock_cnt > -3 && r < 94)) ?
					prqs_pkg::CMD_UNLOCK : prqs_pkg::CMD_LOCK;
			else
				c = CMD_UNKNOWN;
			np = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
			send_beat(c, 5'($urandom_range(31)), np);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fifo order, priority extremes, each ignored case, locking, idle
		send_beat(prqs_pkg::CMD_READY, 5'd31, 5'd0);
		send_beat(prqs_pkg::CMD_READY, 5'd1, 5'd31);
		send_beat(prqs_pkg::CMD_READY, 5'd2, 5'd0);
		send_beat(prqs_pkg::CMD_READY, 5'd2, 5'd4);       // already ready, ignored
		send_beat(prqs_pkg::CMD_RESCHED, 5'd0, 5'd0);     // preempts slot 0
		send_beat(prqs_pkg::CMD_YIELD, 5'd0, 5'd0);       // same level fifo
		send_beat(prqs_pkg::CMD_REPRIO, 5'd1, 5'd31);     // same priority, nothing
		send_beat(prqs_pkg::CMD_REPRIO, 5'd1, 5'd5);
		send_beat(prqs_pkg::CMD_REPRIO, 5'd7, 5'd3);      // status none, ignored
		send_beat(prqs_pkg::CMD_UNREADY, 5'd9, 5'd0);     // status none, ignored
		send_beat(prqs_pkg::CMD_UNREADY, 5'd1, 5'd0);
		send_beat(prqs_pkg::CMD_REPRIO, 5'd2, 5'd20);     // running slot takes new priority
		send_beat(prqs_pkg::CMD_RESCHED, 5'd0, 5'd0);
		send_beat(prqs_pkg::CMD_LOCK, 5'd0, 5'd0);
		send_beat(prqs_pkg::CMD_YIELD, 5'd0, 5'd0);       // locked, nothing
		send_beat(prqs_pkg::CMD_UNLOCK, 5'd0, 5'd0);
		send_beat(prqs_pkg::CMD_UNLOCK, 5'd0, 5'd0);      // goes negative
		send_beat(prqs_pkg::CMD_LOCK, 5'd0, 5'd0);
		send_beat(CMD_UNKNOWN, 5'd31, 5'd31);
		for (int s = 0; s < 32; s++)
			send_beat(prqs_pkg::CMD_UNREADY, 5'(s), 5'd0);
		send_beat(prqs_pkg::CMD_YIELD, 5'd0, 5'd0);       // nothing ready, idle
		send_beat(prqs_pkg::CMD_RESCHED, 5'd0, 5'd0);

		// lock counter up to the top and down to the bottom, then back to zero
		for (int i = 0; i < 130; i++)
			send_beat(prqs_pkg::CMD_LOCK, 5'($urandom_range(31)), 5'($urandom_range(31)));
		for (int i = 0; i < 260; i++)
			send_beat(prqs_pkg::CMD_UNLOCK, 5'($urandom_range(31)),
				5'($urandom_range(31)));
		for (int i = 0; i < 128; i++)
			send_beat(prqs_pkg::CMD_LOCK, 5'($urandom_range(31)), 5'($urandom_range(31)));
		drain();

		// random traffic over the idling phases
		send_random(60);
		send_gap_pct = 45;
		send_random(60);
		hold_req = 1;
		send_gap_pct = 0;
		send_random(30);                        // fills the block while results are held
		drain();                                // sender pauses until all results are in
		stall_pct = 45;
		send_random(60);
		send_gap_pct = 32;
		stall_pct = 32;
		send_random(60);
		send_gap_pct = 0;
		stall_pct = 0;
		send_random(30);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/prqs_pkg.sv
rtl/prqs_ctrl.sv
rtl/prqs_dpath.sv
rtl/priority_ready_queue_scheduler.sv
tb/tb.sv
